### rtl/sact_pkg.sv
// ----------------------------------------------------------------------------
// sact_pkg: shared types and constants of the cache tag controller
// Geometry, address split, per-way entry layout and beat formats.
// ----------------------------------------------------------------------------
`default_nettype none

package sact_pkg;

  // Cache geometry. WAYS and LINE_BYTES are powers of two.
  localparam int SETS       = 64;
  localparam int LINE_BYTES = 16;
  localparam int WAYS       = 4;

  localparam int ADDR_W     = 32;
  localparam int OFF_W      = $clog2(LINE_BYTES);
  localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_BITS   = $clog2(SETS);
  localparam int TAG_W      = ADDR_W - OFF_W - SET_BITS;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W      = $clog2(WAYS + 1);
  localparam int CNT_W      = 32;
  localparam int LFSR_W     = 16;
  localparam int WAY_OUT_W  = 2;

  localparam logic [LFSR_W-1:0] LFSR_SEED = LFSR_W'(1);

  // Operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_REPLACE_LRU  = 2'd0,
    CFG_WRITE_BACK   = 2'd1,
    CFG_NEXT_LEVEL   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             operation;
    logic [ADDR_W-1:0] address;
    logic             whole_line;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 fill_needed;
    logic                 writeback_needed;
    logic [ADDR_W-1:0]    writeback_address;
    logic                 write_through;
    logic                 error;
    logic [CNT_W-1:0]     hits_so_far;
    logic [CNT_W-1:0]     misses_so_far;
  } out_item_t;

  // One way of one set.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [AGE_W-1:0] age;
  } way_entry_t;

  // One set: all ways, kept together in one memory row.
  typedef way_entry_t [WAYS-1:0] set_row_t;

endpackage

`default_nettype wire

### rtl/set_assoc_cache_tag_controller.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller: tag and state controller of a cache
// Hit/miss lookup, victim choice, fill / write-back / write-through flags.
// ----------------------------------------------------------------------------
// Takes one load or store beat per cycle while in_stall is low and returns
// one result beat per access, through the lookup stage register and then the
// result register. The set's row (tags, valid, dirty, age for all ways)
// is read from a single RAM at the accepting edge; the lookup stage then
// decides hit, victim and flags and, when it advances, writes the row back
// and loads the result register. A stalled result holds the lookup stage,
// and the input stalls while it is held. A row written in the cycle that the
// next access reads the same set is forwarded, so back-to-back accesses to
// one set are exact. Rows never written since reset read as all invalid,
// tracked by one flop per set, so there is no clearing pass after reset.
// Configuration (cfg_index 0 replace_lru, 1 write_back_mode,
// 2 next_level_present, all reset to 1) is always ready and must only be
// written with no access in flight. Victim order: first invalid way, else
// the oldest way (lowest index on ties) under LRU, else the LFSR value.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tag_controller (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // access beats
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire sact_pkg::in_item_t   in_data,
  // result beats
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sact_pkg::out_item_t       out_data,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic                 cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic replace_lru_r, write_back_r, next_level_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      replace_lru_r <= 1'b1;
      write_back_r  <= 1'b1;
      next_level_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sact_pkg::CFG_REPLACE_LRU: replace_lru_r <= cfg_data;
        sact_pkg::CFG_WRITE_BACK:  write_back_r  <= cfg_data;
        sact_pkg::CFG_NEXT_LEVEL:  next_level_r  <= cfg_data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake / pipeline control
  // --------------------------------------------------------------------------
  logic                s1_valid_r;
  sact_pkg::in_item_t  s1_item_r;
  logic                out_valid_r;
  sact_pkg::out_item_t out_r;
  logic                in_accept;
  logic                s1_adv;

  // Lookup stage advances when the result register is free or draining.
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Set storage: one RAM row per set, plus a written-since-reset flag per set
  // --------------------------------------------------------------------------
  logic [sact_pkg::SET_W-1:0] rd_set, s1_set;
  logic [sact_pkg::TAG_W-1:0] s1_tag;
  sact_pkg::set_row_t         ram_rd, cur_row, new_row, byp_row_r;
  logic                       byp_hit_r, rowok_r;
  logic [sact_pkg::SETS-1:0]  row_init_r;

  assign rd_set = in_data.address[sact_pkg::OFF_W +: sact_pkg::SET_W];
  assign s1_set = s1_item_r.address[sact_pkg::OFF_W +: sact_pkg::SET_W];
  assign s1_tag = s1_item_r.address[sact_pkg::ADDR_W-1 -: sact_pkg::TAG_W];

  sact_ram #(
    .WIDTH ($bits(sact_pkg::set_row_t)),
    .DEPTH (sact_pkg::SETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_set),
    .wr_data (new_row),
    .rd_en   (in_accept),
    .rd_addr (rd_set),
    .rd_data (ram_rd)
  );

  // Forward the row being written when the next access reads the same set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
      rowok_r   <= 1'b0;
    end else if (in_accept) begin
      byp_hit_r <= s1_adv && (s1_set == rd_set);
      rowok_r   <= row_init_r[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byp_row_r <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
    end else if (s1_adv) begin
      row_init_r[s1_set] <= 1'b1;
    end
  end

  // Unwritten rows read as reset contents: invalid, clean, age zero.
  always_comb begin
    if (byp_hit_r) begin
      cur_row = byp_row_r;
    end else if (rowok_r) begin
      cur_row = ram_rd;
    end else begin
      cur_row = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Lookup stage stage 2: hit search, victim choice, row update
  // --------------------------------------------------------------------------
  logic                        is_store;
  logic                        found, have_free;
  logic [sact_pkg::WAY_W-1:0]  hit_way, free_way, lru_way, way;
  logic [sact_pkg::LFSR_W-1:0] lfsr_r, lfsr_step, lfsr_nxt;
  logic                        lfsr_bit;
  logic [sact_pkg::AGE_W-1:0]  cur_age;
  logic                        fill, wb, wt, err;
  logic [sact_pkg::ADDR_W-1:0] wb_addr;
  logic [sact_pkg::CNT_W-1:0]  hit_cnt_r, miss_cnt_r, hit_cnt_nxt, miss_cnt_nxt;

  assign is_store = (s1_item_r.operation == sact_pkg::OP_STORE);

  // First valid way with matching tag, first invalid way, oldest way.
  always_comb begin
    found    = 1'b0;
    hit_way  = '0;
    have_free = 1'b0;
    free_way = '0;
    lru_way  = '0;
    for (int w = 0; w < sact_pkg::WAYS; w++) begin
      if (!found && cur_row[w].valid && (cur_row[w].tag == s1_tag)) begin
        found   = 1'b1;
        hit_way = sact_pkg::WAY_W'(w);
      end
      if (!have_free && !cur_row[w].valid) begin
        have_free = 1'b1;
        free_way  = sact_pkg::WAY_W'(w);
      end
      if (cur_row[w].age > cur_row[lru_way].age) begin
        lru_way = sact_pkg::WAY_W'(w);
      end
    end
  end

  // Fibonacci LFSR, taps 16,14,13,11.
  assign lfsr_bit  = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];
  assign lfsr_step = {lfsr_bit, lfsr_r[sact_pkg::LFSR_W-1:1]};

  always_comb begin
    new_row      = cur_row;
    way          = '0;
    fill         = 1'b0;
    wb           = 1'b0;
    wt           = 1'b0;
    err          = 1'b0;
    wb_addr      = '0;
    lfsr_nxt     = lfsr_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    cur_age      = '0;

    if (found) begin
      hit_cnt_nxt = hit_cnt_r + sact_pkg::CNT_W'(1);
      way         = hit_way;
      if (is_store) begin
        if (write_back_r) begin
          new_row[way].dirty = 1'b1;
        end else begin
          new_row[way].dirty = 1'b0;
          wt                 = next_level_r;
        end
      end
    end else begin
      miss_cnt_nxt = miss_cnt_r + sact_pkg::CNT_W'(1);
      fill         = !is_store || !s1_item_r.whole_line;
      if (fill && !next_level_r) begin
        err = 1'b1;
      end else begin
        if (have_free) begin
          way = free_way;
        end else begin
          if (replace_lru_r) begin
            way = lru_way;
          end else begin
            // generator steps even if the miss then errors out
            lfsr_nxt = lfsr_step;
            way      = lfsr_step[sact_pkg::WAY_W-1:0];
          end
          if (cur_row[way].dirty) begin
            if (!next_level_r) begin
              err = 1'b1;
            end else begin
              wb      = 1'b1;
              wb_addr = sact_pkg::ADDR_W'({cur_row[way].tag, s1_set,
                                           {sact_pkg::OFF_W{1'b0}}});
            end
          end
        end
        if (!err) begin
          new_row[way].valid = 1'b1;
          new_row[way].tag   = s1_tag;
          new_row[way].dirty = is_store && write_back_r;
          if (replace_lru_r) begin
            new_row[way].age = sact_pkg::AGE_W'(sact_pkg::WAYS);
          end
          wt = is_store && !write_back_r && next_level_r;
        end
      end
    end

    if (err) begin
      way     = '0;
      fill    = 1'b0;
      wb      = 1'b0;
      wb_addr = '0;
      wt      = 1'b0;
    end else if (replace_lru_r) begin
      // touch: valid ways younger than the touched one age by one
      cur_age = new_row[way].age;
      for (int w = 0; w < sact_pkg::WAYS; w++) begin
        if (new_row[w].valid && (new_row[w].age < cur_age)) begin
          new_row[w].age = new_row[w].age + sact_pkg::AGE_W'(1);
        end
      end
      new_row[way].age = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage registers, counters, generator
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      lfsr_r      <= sact_pkg::LFSR_SEED;
    end else begin
      s1_valid_r  <= in_accept || (s1_valid_r && !s1_adv);
      out_valid_r <= s1_adv || (out_valid_r && out_stall);
      if (s1_adv) begin
        hit_cnt_r  <= hit_cnt_nxt;
        miss_cnt_r <= miss_cnt_nxt;
        lfsr_r     <= lfsr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_r.hit               <= found;
      out_r.way_used          <= sact_pkg::WAY_OUT_W'(way);
      out_r.fill_needed       <= fill;
      out_r.writeback_needed  <= wb;
      out_r.writeback_address <= wb_addr;
      out_r.write_through     <= wt;
      out_r.error             <= err;
      out_r.hits_so_far       <= hit_cnt_nxt;
      out_r.misses_so_far     <= miss_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // every processed access bumps exactly one counter
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> ((hit_cnt_r + miss_cnt_r) ==
                ($past(hit_cnt_r + miss_cnt_r) + sact_pkg::CNT_W'(1))))
    else $error("hit+miss count did not advance by one");

  // an errored result carries no action flags
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.error) |->
      (!out_r.hit && !out_r.fill_needed && !out_r.writeback_needed &&
       !out_r.write_through && (out_r.way_used == '0)))
    else $error("error result with action flags set");

  // write-back or fill only on a miss
  a_wb_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.writeback_needed || out_r.fill_needed)) |-> !out_r.hit)
    else $error("fill or write-back reported on a hit");

  // a processed access always lands in the result register
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("processed access lost");

  // a held result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !s1_adv)
    else $error("lookup advanced into a stalled result");
`endif

endmodule

`default_nettype wire

### rtl/sact_ram.sv
// ----------------------------------------------------------------------------
// sact_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for set_assoc_cache_tag_controller
// Directed and random loads and stores under every replacement, store-policy
// and next-level setting. A predictor of tags, dirty marks, ages,
// the LFSR and the hit / miss counters scores every result beat in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_AT     = 600;   // access count that starts the long hold
  localparam int HOLD_LEN    = 300;   // cycles the result side stays stalled
  localparam int PHASE_LEN   = 170;   // random accesses per setting

  logic clk;
  logic rst_n = 1'b0;

  // Access side: driven at the falling edge from a queue.
  logic                in_valid = 1'b0;
  logic                in_stall;
  sact_pkg::in_item_t  in_data  = '0;
  logic                in_took  = 1'b0;   // beat moved at the last rising edge
  sact_pkg::in_item_t  access_q[$];
  int                  in_gap   = 0;

  // Result side.
  logic                out_valid;
  logic                out_stall = 1'b0;
  sact_pkg::out_item_t out_data;
  int                  stall_left = 0;
  int                  hold_left  = 0;
  logic                hold_on    = 1'b0;
  logic                hold_done  = 1'b0;

  // Config port.
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  sact_pkg::cfg_idx_t  cfg_index = sact_pkg::CFG_REPLACE_LRU;
  logic                cfg_data  = 1'b0;
  int                  cfg_writes = 0;

  logic      quiet = 1'b0;           // no idling on either side once set
  int        accepted = 0;
  int        fail_cnt = 0;
  int        cycle_cnt = 0;

  // Predicted cache state, mirrors the controller.
  bit [sact_pkg::TAG_W-1:0]  tag_store [sact_pkg::SETS][sact_pkg::WAYS];
  bit                        tag_valid [sact_pkg::SETS][sact_pkg::WAYS];
  bit                        tag_dirty [sact_pkg::SETS][sact_pkg::WAYS];
  bit [sact_pkg::AGE_W-1:0]  tag_age   [sact_pkg::SETS][sact_pkg::WAYS];
  bit [sact_pkg::CNT_W-1:0]  hit_total  = '0;
  bit [sact_pkg::CNT_W-1:0]  miss_total = '0;
  bit [sact_pkg::LFSR_W-1:0] lfsr_q     = sact_pkg::LFSR_SEED;
  bit                        lru_mode = 1'b1;
  bit                        wb_mode  = 1'b1;
  bit                        next_lvl = 1'b1;

  sact_pkg::out_item_t pending_results[$];

  set_assoc_cache_tag_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Lookup predictor: applies one access to the mirrored state and returns
  // the beat the controller must produce for it.
  // --------------------------------------------------------------------------
  function automatic sact_pkg::out_item_t lookup_access(input sact_pkg::in_item_t acc);
    sact_pkg::out_item_t      r;
    logic [sact_pkg::TAG_W-1:0] tg;
    int                       st;
    int                       w;
    int                       wy;
    bit                       found;
    bit                       fill;
    bit                       err;
    bit                       have_free;
    bit                       fb;
    bit [sact_pkg::AGE_W-1:0] cur;
    r     = '0;
    tg    = acc.address[sact_pkg::ADDR_W-1 -: sact_pkg::TAG_W];
    st    = int'(acc.address[sact_pkg::OFF_W +: sact_pkg::SET_BITS]);
    found = 1'b0;
    fill  = 1'b0;
    err   = 1'b0;
    wy    = 0;
    for (w = 0; w < sact_pkg::WAYS; w++) begin
      if (!found && tag_valid[st][w] && tag_store[st][w] == tg) begin
        found = 1'b1;
        wy    = w;
      end
    end
    if (found) begin
      hit_total = hit_total + 1'b1;
      if (acc.operation == sact_pkg::OP_STORE) begin
        if (wb_mode) begin
          tag_dirty[st][wy] = 1'b1;
        end else begin
          tag_dirty[st][wy] = 1'b0;
          r.write_through   = next_lvl;
        end
      end
    end else begin
      miss_total = miss_total + 1'b1;
      // partial stores need the rest of the line, loads need all of it
      fill = (acc.operation == sact_pkg::OP_LOAD) || !acc.whole_line;
      err  = fill && !next_lvl;
      if (!err) begin
        have_free = 1'b0;
        for (w = 0; w < sact_pkg::WAYS; w++) begin
          if (!have_free && !tag_valid[st][w]) begin
            wy        = w;
            have_free = 1'b1;
          end
        end
        if (!have_free) begin
          if (lru_mode) begin
            wy = 0;
            for (w = 1; w < sact_pkg::WAYS; w++)
              if (tag_age[st][w] > tag_age[st][wy]) wy = w;
          end else begin
            // steps even when the victim later turns out to be unusable
            fb     = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
            lfsr_q = {fb, lfsr_q[sact_pkg::LFSR_W-1:1]};
            wy     = int'(lfsr_q % sact_pkg::WAYS);
          end
          if (tag_dirty[st][wy]) begin
            if (!next_lvl) begin
              err = 1'b1;
            end else begin
              r.writeback_needed  = 1'b1;
              r.writeback_address = {tag_store[st][wy], st[sact_pkg::SET_BITS-1:0],
                                     {sact_pkg::OFF_W{1'b0}}};
            end
          end
        end
        if (!err) begin
          tag_valid[st][wy] = 1'b1;
          tag_store[st][wy] = tg;
          tag_dirty[st][wy] = (acc.operation == sact_pkg::OP_STORE) && wb_mode;
          if (lru_mode) tag_age[st][wy] = sact_pkg::AGE_W'(sact_pkg::WAYS);
          if (acc.operation == sact_pkg::OP_STORE && !wb_mode)
            r.write_through = next_lvl;
        end
      end
    end
    if (err) begin
      r       = '0;
      r.error = 1'b1;
    end else begin
      r.hit         = found;
      r.way_used    = sact_pkg::WAY_OUT_W'(wy);
      r.fill_needed = fill;
      if (lru_mode) begin
        cur = tag_age[st][wy];
        for (w = 0; w < sact_pkg::WAYS; w++)
          if (tag_valid[st][w] && tag_age[st][w] < cur)
            tag_age[st][w] = tag_age[st][w] + 1'b1;
        tag_age[st][wy] = '0;
      end
    end
    r.hits_so_far   = hit_total;
    r.misses_so_far = miss_total;
    return r;
  endfunction

  function automatic string describe(input sact_pkg::out_item_t r);
    return {$sformatf("hit=%0d way=%0d fill=%0d wb=%0d wb_addr=%08h",
                      r.hit, r.way_used, r.fill_needed, r.writeback_needed,
                      r.writeback_address),
            $sformatf(" wt=%0d err=%0d hits=%0d misses=%0d",
                      r.write_through, r.error, r.hits_so_far, r.misses_so_far)};
  endfunction

  task automatic report_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Rising edge: record beats on all three channels, predict, score.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sact_pkg::out_item_t want;
    in_took <= in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sact_pkg::CFG_REPLACE_LRU: lru_mode = cfg_data;
          sact_pkg::CFG_WRITE_BACK:  wb_mode  = cfg_data;
          sact_pkg::CFG_NEXT_LEVEL:  next_lvl = cfg_data;
          default: ;
        endcase
        cfg_writes <= cfg_writes + 1;
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(lookup_access(in_data));
        accepted <= accepted + 1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_fail($sformatf("result beat with nothing pending: %s",
                                describe(out_data)));
        end else begin
          want = pending_results.pop_front();
          if (out_data.hit               !== want.hit               ||
              out_data.way_used          !== want.way_used          ||
              out_data.fill_needed       !== want.fill_needed       ||
              out_data.writeback_needed  !== want.writeback_needed  ||
              out_data.writeback_address !== want.writeback_address ||
              out_data.write_through     !== want.write_through     ||
              out_data.error             !== want.error             ||
              out_data.hits_so_far       !== want.hits_so_far       ||
              out_data.misses_so_far     !== want.misses_so_far)
            report_fail($sformatf("mismatch\n  want %s\n  got  %s",
                                  describe(want), describe(out_data)));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Access driver: a new beat goes out only once the current one moved.
  // Random gaps between beats, none in the quiet tail.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(0, 14);
      end else if (access_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= access_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long hold on the result side: the pipe fills and in_stall must rise
  // while the driver keeps offering beats.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      hold_on   <= (hold_left != 1);
    end else if (!hold_done && accepted >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_on   <= 1'b1;
      hold_done <= 1'b1;
    end
  end

  // Result receiver: random stall bursts.
  always @(negedge clk) begin
    if (hold_on) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Run limit.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[set_assoc_cache_tag_controller] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_access(input logic op, input logic [sact_pkg::ADDR_W-1:0] addr,
                            input logic whole);
    sact_pkg::in_item_t a;
    a.operation  = op;
    a.address    = addr;
    a.whole_line = whole;
    access_q.push_back(a);
  endtask

  function automatic logic [sact_pkg::ADDR_W-1:0] line_address(input int tg, input int st);
    return {sact_pkg::TAG_W'(tg), sact_pkg::SET_BITS'(st), {sact_pkg::OFF_W{1'b0}}};
  endfunction

  // Wait until every beat has gone in and come back, then let the pipe settle.
  task automatic wait_drain();
    do @(posedge clk);
    while (access_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input sact_pkg::cfg_idx_t idx, input logic val);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk);
    while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic lru, input logic wb, input logic nl);
    write_cfg(sact_pkg::CFG_REPLACE_LRU, lru);
    write_cfg(sact_pkg::CFG_WRITE_BACK, wb);
    write_cfg(sact_pkg::CFG_NEXT_LEVEL, nl);
  endtask

  initial begin
    // random phases: {replace_lru, write_back_mode, next_level_present}
    logic [2:0]                 phase_cfg [8];
    logic [sact_pkg::TAG_W-1:0] tag_pool [6];
    int                         hot_set [4];
    int                         p;
    int                         k;
    phase_cfg = '{3'b111, 3'b011, 3'b101, 3'b001, 3'b110, 3'b000, 3'b010, 3'b111};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: LRU, write back, next level present.
    add_access(sact_pkg::OP_LOAD,  32'h0000_0000, 1'b0);     // cold miss, fill
    add_access(sact_pkg::OP_LOAD,  32'h0000_000F, 1'b0);     // hit, last byte
    add_access(sact_pkg::OP_STORE, 32'h0000_0004, 1'b0);     // store hit marks dirty
    add_access(sact_pkg::OP_STORE, 32'hFFFF_FFFF, 1'b1);     // top address, no fill
    add_access(sact_pkg::OP_LOAD,  32'hFFFF_FFF0, 1'b0);
    for (k = 1; k <= 4; k++)                                 // fill set 1 with dirty lines
      add_access(sact_pkg::OP_STORE, line_address(k, 1), 1'b1);
    add_access(sact_pkg::OP_LOAD,  line_address(5, 1), 1'b0); // oldest way dirty: write back
    add_access(sact_pkg::OP_LOAD,  line_address(1, 1), 1'b0);
    // fill plus write back
    add_access(sact_pkg::OP_STORE, line_address(6, 1) + 3, 1'b0);
    add_access(sact_pkg::OP_STORE, line_address(7, 1), 1'b1);
    wait_drain();

    // Write through.
    write_cfg(sact_pkg::CFG_WRITE_BACK, 1'b0);
    add_access(sact_pkg::OP_STORE, 32'h0000_0008, 1'b0);     // hit, copy down, clears dirty
    add_access(sact_pkg::OP_STORE, line_address(8, 2), 1'b1);
    add_access(sact_pkg::OP_STORE, line_address(9, 2) + 1, 1'b0);
    wait_drain();

    // No next level: fills are impossible.
    write_cfg(sact_pkg::CFG_NEXT_LEVEL, 1'b0);
    add_access(sact_pkg::OP_LOAD,  line_address(10, 3), 1'b0); // error
    add_access(sact_pkg::OP_STORE, line_address(11, 3), 1'b1); // free way, fine
    add_access(sact_pkg::OP_STORE, line_address(8, 2), 1'b0);  // hit, no copy possible
    wait_drain();

    // Write back without next level: a dirty victim cannot leave.
    write_cfg(sact_pkg::CFG_WRITE_BACK, 1'b1);
    add_access(sact_pkg::OP_STORE, line_address(12, 1), 1'b1);
    add_access(sact_pkg::OP_STORE, line_address(13, 1), 1'b1);
    add_access(sact_pkg::OP_STORE, line_address(14, 1), 1'b1);
    wait_drain();

    // Random victim on a full set.
    write_cfg(sact_pkg::CFG_REPLACE_LRU, 1'b0);
    write_cfg(sact_pkg::CFG_NEXT_LEVEL, 1'b1);
    add_access(sact_pkg::OP_LOAD, line_address(15, 1), 1'b0);
    add_access(sact_pkg::OP_LOAD, line_address(16, 1), 1'b0);
    wait_drain();

    // Random part. Traffic is aimed at a few hot sets and a small pool of
    // tags so that hits, evictions and dirty victims are frequent; a share
    // of fully random addresses keeps every address bit moving.
    for (p = 0; p < 8; p++) begin
      if (p % 2 == 0) begin
        for (k = 0; k < 6; k++) tag_pool[k] = sact_pkg::TAG_W'($urandom);
        for (k = 0; k < 4; k++) hot_set[k] = $urandom_range(0, sact_pkg::SETS - 1);
      end
      apply_settings(phase_cfg[p][2], phase_cfg[p][1], phase_cfg[p][0]);
      if (p == 7) quiet = 1'b1;
      for (k = 0; k < PHASE_LEN; k++) begin
        if ($urandom_range(0, 99) < 15)
          add_access(logic'($urandom_range(0, 1)), $urandom, logic'($urandom_range(0, 1)));
        else
          add_access(logic'($urandom_range(0, 1)),
                     {tag_pool[$urandom_range(0, 5)],
                      sact_pkg::SET_BITS'(hot_set[$urandom_range(0, 3)]),
                      sact_pkg::OFF_W'($urandom)},
                     logic'($urandom_range(0, 1)));
      end
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (fail_cnt == 0)
      $display("[set_assoc_cache_tag_controller] OK");
    else
      $display("[set_assoc_cache_tag_controller] ERROR");
    $finish;
  end

endmodule
